@@ rtl/dct8_forward_inverse_macros.svh @@
// Assertion macros used by the transform RTL.
// Each macro expects signals named clk and rst_n in the using scope.
`ifndef DCT8_FORWARD_INVERSE_MACROS_SVH
`define DCT8_FORWARD_INVERSE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCT8_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCT8_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/dct8_pkg.sv @@
package dct8_pkg;

  // Vector length, port width and coefficient format.
  localparam int NPTS      = 8;
  localparam int IO_W      = 16;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 15;

  // Pipeline depth: input, products, pair sums, accumulate, output.
  localparam int NSTG = 5;

  // Per-stage load enables handed to every lane.
  typedef struct packed {
    logic [NSTG-1:0] load;
  } pipe_ctl_t;

  typedef logic signed [COEF_W-1:0] coef_t;

  // C[k][m] = s_k * cos(pi * k * (2m+1) / 16) in Q1.15, normalisation folded in.
  localparam coef_t DCT_COEF [NPTS][NPTS] = '{
    '{16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585,
      16'sd11585, 16'sd11585, 16'sd11585, 16'sd11585},
    '{16'sd16069, 16'sd13623, 16'sd9102, 16'sd3196,
      -16'sd3196, -16'sd9102, -16'sd13623, -16'sd16069},
    '{16'sd15137, 16'sd6270, -16'sd6270, -16'sd15137,
      -16'sd15137, -16'sd6270, 16'sd6270, 16'sd15137},
    '{16'sd13623, -16'sd3196, -16'sd16069, -16'sd9102,
      16'sd9102, 16'sd16069, 16'sd3196, -16'sd13623},
    '{16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585,
      16'sd11585, -16'sd11585, -16'sd11585, 16'sd11585},
    '{16'sd9102, -16'sd16069, 16'sd3196, 16'sd13623,
      -16'sd13623, -16'sd3196, 16'sd16069, -16'sd9102},
    '{16'sd6270, -16'sd15137, 16'sd15137, -16'sd6270,
      -16'sd6270, 16'sd15137, -16'sd15137, 16'sd6270},
    '{16'sd3196, -16'sd9102, 16'sd13623, -16'sd16069,
      16'sd16069, -16'sd13623, 16'sd9102, -16'sd3196}
  };

endpackage

@@ rtl/dct8_lane.sv @@
module dct8_lane
  import dct8_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  pipe_ctl_t                      ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] x [NPTS],
  input  coef_t                          coef [NPTS],
  output logic signed [IO_W-1:0]         y
);

  localparam int PW = SAMPLE_WIDTH + COEF_W;
  localparam int SW = PW + 1;
  localparam int AW = PW + 3;
  localparam int QW = AW - COEF_FRAC;
  localparam logic signed [QW-1:0] Q_HI = QW'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [QW-1:0] Q_LO = QW'(-(1 << (SAMPLE_WIDTH - 1)));
  localparam logic [AW-1:0] RND_BIAS = AW'((1 << COEF_FRAC) - 1);

  logic signed [PW-1:0]           prod_r   [NPTS];
  logic signed [PW-1:0]           prod_nxt [NPTS];
  logic signed [SW-1:0]           pair_r   [NPTS/2];
  logic signed [SW-1:0]           pair_nxt [NPTS/2];
  logic signed [AW-1:0]           acc_r;
  logic signed [AW-1:0]           acc_nxt;
  logic signed [AW-1:0]           biased;
  logic signed [QW-1:0]           quot;
  logic signed [SAMPLE_WIDTH-1:0] sat;
  logic signed [IO_W-1:0]         y_r;
  logic signed [IO_W-1:0]         y_nxt;

  // One product per sample and coefficient.
  always_comb begin
    for (int j = 0; j < NPTS; j++) begin
      prod_nxt[j] = PW'(x[j]) * PW'(coef[j]);
    end
  end

  // First level of the adder tree: neighbouring pairs.
  always_comb begin
    for (int p = 0; p < NPTS/2; p++) begin
      pair_nxt[p] = SW'(prod_r[2*p]) + SW'(prod_r[2*p+1]);
    end
  end

  // Remaining two levels of the tree form the full sum.
  always_comb begin
    acc_nxt = (AW'(pair_r[0]) + AW'(pair_r[1])) + (AW'(pair_r[2]) + AW'(pair_r[3]));
  end

  // Divide by 2^15 rounding toward zero, then clamp to the sample range.
  always_comb begin
    biased = acc_r + (acc_r[AW-1] ? $signed(RND_BIAS) : $signed(AW'(0)));
    quot   = biased[AW-1:COEF_FRAC];
    priority if (quot > Q_HI) begin
      sat = Q_HI[SAMPLE_WIDTH-1:0];
    end else if (quot < Q_LO) begin
      sat = Q_LO[SAMPLE_WIDTH-1:0];
    end else begin
      sat = quot[SAMPLE_WIDTH-1:0];
    end
    y_nxt = IO_W'(sat);
  end

  // Payload registers, each loaded when its stage advances.
  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      prod_r <= prod_nxt;
    end
    if (ctl.load[2]) begin
      pair_r <= pair_nxt;
    end
    if (ctl.load[3]) begin
      acc_r <= acc_nxt;
    end
    if (ctl.load[4]) begin
      y_r <= y_nxt;
    end
  end

  assign y = y_r;

endmodule

@@ rtl/dct8_forward_inverse.sv @@
// Eight-point orthonormal DCT-II (forward) and DCT-III (inverse) engine.
// Input channel: in_valid with in_0..in_7, held off by in_stall. A
// transaction takes place on a rising edge with in_valid high and in_stall low.
// Result channel: out_valid with out_0..out_7, held off by out_stall.
// Configuration: cfg_wr_en with cfg_wr_data writes the direction bit
// (0 forward, 1 inverse); the user must see that it is written only while the
// pipeline is empty, as the block itself does not enforce it. Samples are the
// low SAMPLE_WIDTH bits of each input, sign-extended; results are truncated
// toward zero and clamped to the SAMPLE_WIDTH range. A vector passes through
// the input, product, pair-sum, accumulate and output registers in turn.
// Throughput: one vector per cycle while out_stall stays low, set by the
// five-stage pipeline (input register, 64 multipliers, pair adders,
// final adders, round and clamp output register); out_valid flags its result.
// When out_stall is high the result holds and empty stages behind it still
// fill; in_stall rises only once all five stages hold data.
// Reset (rst_n low, synchronous) empties the pipeline and selects forward.
`include "dct8_forward_inverse_macros.svh"

module dct8_forward_inverse
  import dct8_pkg::*;
#(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [IO_W-1:0] in_0,
  input  logic signed [IO_W-1:0] in_1,
  input  logic signed [IO_W-1:0] in_2,
  input  logic signed [IO_W-1:0] in_3,
  input  logic signed [IO_W-1:0] in_4,
  input  logic signed [IO_W-1:0] in_5,
  input  logic signed [IO_W-1:0] in_6,
  input  logic signed [IO_W-1:0] in_7,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [IO_W-1:0] out_0,
  output logic signed [IO_W-1:0] out_1,
  output logic signed [IO_W-1:0] out_2,
  output logic signed [IO_W-1:0] out_3,
  output logic signed [IO_W-1:0] out_4,
  output logic signed [IO_W-1:0] out_5,
  output logic signed [IO_W-1:0] out_6,
  output logic signed [IO_W-1:0] out_7
);

  logic                           direction_r;
  logic [NSTG-1:0]                v_r;
  logic [NSTG-1:0]                v_nxt;
  logic [NSTG-1:0]                stg_rdy;
  pipe_ctl_t                      ctl;
  logic signed [IO_W-1:0]         in_vec [NPTS];
  logic signed [SAMPLE_WIDTH-1:0] x_s0_r [NPTS];
  logic                           dir_s0_r;
  coef_t                          coef_sel [NPTS][NPTS];
  logic signed [IO_W-1:0]         y [NPTS];

  // Direction register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
    end else if (cfg_wr_en) begin
      direction_r <= cfg_wr_data;
    end
  end

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    stg_rdy[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int s = NSTG - 2; s >= 0; s--) begin
      stg_rdy[s] = !v_r[s] || stg_rdy[s+1];
    end
    v_nxt[0] = stg_rdy[0] ? in_valid : v_r[0];
    for (int s = 1; s < NSTG; s++) begin
      v_nxt[s] = stg_rdy[s] ? v_r[s-1] : v_r[s];
    end
    ctl.load = stg_rdy;
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !stg_rdy[0];
  assign out_valid = v_r[NSTG-1];

  // Input register: keep the low sample bits and the direction of this vector.
  assign in_vec = '{in_0, in_1, in_2, in_3, in_4, in_5, in_6, in_7};

  always_ff @(posedge clk) begin
    if (stg_rdy[0]) begin
      for (int j = 0; j < NPTS; j++) begin
        x_s0_r[j] <= in_vec[j][SAMPLE_WIDTH-1:0];
      end
      dir_s0_r <= direction_r;
    end
  end

  // Inverse uses the transposed coefficient matrix.
  always_comb begin
    for (int i = 0; i < NPTS; i++) begin
      for (int j = 0; j < NPTS; j++) begin
        coef_sel[i][j] = dir_s0_r ? DCT_COEF[j][i] : DCT_COEF[i][j];
      end
    end
  end

  // One dot-product lane per result element.
  for (genvar i = 0; i < NPTS; i++) begin : g_lane
    dct8_lane #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_lane (
      .clk  (clk),
      .ctl  (ctl),
      .x    (x_s0_r),
      .coef (coef_sel[i]),
      .y    (y[i])
    );
  end

  assign out_0 = y[0];
  assign out_1 = y[1];
  assign out_2 = y[2];
  assign out_3 = y[3];
  assign out_4 = y[4];
  assign out_5 = y[5];
  assign out_6 = y[6];
  assign out_7 = y[7];

  // Input is held off only when every stage is occupied.
  `DCT8_ASSERT_SAME(a_stall_only_full, in_stall, (&v_r), "in_stall with a free stage")
  // A vector in the input register that may advance reaches the product stage.
  `DCT8_ASSERT_NEXT(a_s0_advances, (v_r[0] && stg_rdy[1]), v_r[1], "vector lost after input")
  // An accepted vector carries the direction in force when it was taken.
  `DCT8_ASSERT_NEXT(a_dir_captured, (in_valid && !in_stall),
                    (v_r[0] && (dir_s0_r == $past(direction_r))), "direction not captured")

endmodule

@@ sim/dct8_forward_inverse_test.sv @@
`timescale 1ns / 100ps

module dct8_forward_inverse_test
  import dct8_pkg::*;
;

  localparam int SAMPLE_W    = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES  = 6;
  localparam int NUM_FIXED   = 10;

  localparam bit DIR_FORWARD = 1'b0;
  localparam bit DIR_INVERSE = 1'b1;

  // One vector of eight 16-bit elements, element 0 in the lowest slice.
  typedef logic [NPTS-1:0][IO_W-1:0] vec_t;

  // Scoreboard: predicts each transformed vector and checks results in order.
  class dct8_scoreboard #(int SW = 16);
    bit inverse_mode;
    vec_t expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      inverse_mode = DIR_FORWARD;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    // 16384 * cos(ph * pi / 16), from the first quarter wave.
    static function longint half_cosine(int unsigned ph);
      case (ph)
        0:       return 16384;
        1:       return 16069;
        2:       return 15137;
        3:       return 13623;
        4:       return 11585;
        5:       return 9102;
        6:       return 6270;
        7:       return 3196;
        default: return 0;
      endcase
    endfunction

    // Q1.15 weight of frequency k at sample position m, scaling folded in.
    static function longint cos_weight(int unsigned k, int unsigned m);
      int unsigned ph;
      if (k == 0) return 11585;
      ph = (k * (2 * m + 1)) % 32;
      if (ph > 16) ph = 32 - ph;
      if (ph > 8) return -half_cosine(16 - ph);
      return half_cosine(ph);
    endfunction

    function vec_t transform(vec_t x);
      longint xs [NPTS];
      longint acc;
      longint q;
      longint hi;
      longint lo;
      vec_t y;
      hi = (longint'(1) <<< (SW - 1)) - 1;
      lo = -hi - 1;
      for (int i = 0; i < NPTS; i++) xs[i] = longint'($signed(x[i][SW-1:0]));
      for (int k = 0; k < NPTS; k++) begin
        acc = 0;
        for (int m = 0; m < NPTS; m++) begin
          if (inverse_mode) acc += xs[m] * cos_weight(m, k);
          else acc += xs[m] * cos_weight(k, m);
        end
        // Integer division truncates toward zero, then the range clamp.
        q = acc / (longint'(1) <<< COEF_FRAC);
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        y[k] = q[IO_W-1:0];
      end
      return y;
    endfunction

    function void set_direction(bit inv);
      inverse_mode = inv;
    endfunction

    function void note_input(vec_t x);
      expected_q.push_back(transform(x));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(vec_t got);
      vec_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results_seen));
        return;
      end
      want = expected_q.pop_front();
      for (int i = 0; i < NPTS; i++) begin
        if (got[i] !== want[i])
          report($sformatf("result %0d out_%0d: got %0d, expected %0d", results_seen, i,
                           $signed(got[i]), $signed(want[i])));
      end
    endtask
  endclass

  typedef dct8_scoreboard #(SAMPLE_W) scoreboard_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic cfg_wr_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [IO_W-1:0] in_0 = '0, in_1 = '0, in_2 = '0, in_3 = '0;
  logic signed [IO_W-1:0] in_4 = '0, in_5 = '0, in_6 = '0, in_7 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [IO_W-1:0] out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7;

  // One in idle_odds chance of an idle burst per opportunity; zero turns idling off.
  int unsigned idle_odds = 0;
  int unsigned quiet_cycles = 0;
  scoreboard_t sb = new();

  dct8_forward_inverse #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_0       (in_0),
    .in_1       (in_1),
    .in_2       (in_2),
    .in_3       (in_3),
    .in_4       (in_4),
    .in_5       (in_5),
    .in_6       (in_6),
    .in_7       (in_7),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_0      (out_0),
    .out_1      (out_1),
    .out_2      (out_2),
    .out_3      (out_3),
    .out_4      (out_4),
    .out_5      (out_5),
    .out_6      (out_6),
    .out_7      (out_7)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Monitor both channels at each edge, and end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input({in_7, in_6, in_5, in_4, in_3, in_2, in_1, in_0});
      if (out_valid && !out_stall)
        sb.check_result({out_7, out_6, out_5, out_4, out_3, out_2, out_1, out_0});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The result side stalls in random bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk);
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_direction(bit dir);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= dir;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_direction(dir);
  endtask

  // Offers one vector, with an optional idle burst ahead of it, and waits for the transaction.
  task automatic send_vector(vec_t v);
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_7, in_6, in_5, in_4, in_3, in_2, in_1, in_0} <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // Lets the pipeline empty before the direction may change.
  // The first edge makes sure the last input transaction has been noted.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (NSTG + 3) @(posedge clk);
  endtask

  // Extremes, impulses and ramps; several saturate in either direction.
  function automatic vec_t fixed_vector(int idx);
    vec_t v;
    for (int i = 0; i < NPTS; i++) begin
      case (idx)
        0:       v[i] = 16'h0000;
        1:       v[i] = 16'h7FFF;
        2:       v[i] = 16'h8000;
        3:       v[i] = i[0] ? 16'h8000 : 16'h7FFF;
        4:       v[i] = i[0] ? 16'h7FFF : 16'h8000;
        5:       v[i] = (i == 0) ? 16'h7FFF : 16'h0000;
        6:       v[i] = (i == 7) ? 16'h8000 : 16'h0000;
        7:       v[i] = 16'hFFFF;
        8:       v[i] = 16'h0001;
        default: v[i] = IO_W'(i * 9000 - 32000);
      endcase
    end
    return v;
  endfunction

  // Mixed full-range, small and saturating vectors.
  function automatic vec_t random_vector();
    vec_t v;
    int unsigned row;
    int unsigned mag;
    case ($urandom_range(0, 7))
      0: begin
        // Signs follow one basis row, so that frequency's sum is large.
        row = $urandom_range(0, NPTS - 1);
        for (int i = 0; i < NPTS; i++) begin
          mag  = $urandom_range(16000, 32767);
          v[i] = (sb.cos_weight(row, i) < 0) ? IO_W'(-int'(mag)) : IO_W'(mag);
        end
      end
      1: begin
        // Small values, where truncation toward zero shows on negative sums.
        for (int i = 0; i < NPTS; i++) v[i] = IO_W'(int'($urandom_range(0, 127)) - 64);
      end
      default: begin
        for (int i = 0; i < NPTS; i++) begin
          case ($urandom_range(0, 9))
            0:       v[i] = 16'h7FFF;
            1:       v[i] = 16'h8000;
            2:       v[i] = IO_W'(int'($urandom_range(0, 31)) - 16);
            default: v[i] = IO_W'($urandom);
          endcase
        end
      end
    endcase
    return v;
  endfunction

  // Reset, directed vectors in both directions, then random phases.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_direction(DIR_FORWARD);
    for (int i = 0; i < NUM_FIXED; i++) send_vector(fixed_vector(i));
    drain_pipeline();
    write_direction(DIR_INVERSE);
    for (int i = 0; i < NUM_FIXED; i++) send_vector(fixed_vector(i));
    drain_pipeline();

    // Heavy, light and no idling in turn; the final phase runs with none.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       idle_odds = 2;
        1:       idle_odds = 6;
        2:       idle_odds = 0;
        3:       idle_odds = 3;
        4:       idle_odds = 12;
        default: idle_odds = 0;
      endcase
      write_direction(p[0] ? DIR_FORWARD : DIR_INVERSE);
      for (int i = 0; i < PHASE_ITEMS; i++) send_vector(random_vector());
      drain_pipeline();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dct8_pkg.sv
rtl/dct8_lane.sv
rtl/dct8_forward_inverse.sv
sim/dct8_forward_inverse_test.sv
